// File: rtl/core/rrva_pkg.sv
// Package for the round-robin voice allocator.
// Holds field widths, register indexes and the scan token and control types.
// No dependencies.
package rrva_pkg;

	localparam int DEF_MAX_VOICES = 16;
	localparam int DEF_TIME_BITS  = 48;

	// sized for the largest voice count the design supports (64)
	localparam int VIDX_W = 6;
	localparam int VCNT_W = 7;

	localparam int NOW_W     = 48;
	localparam int DUR_W     = 24;
	localparam int HALF_W    = 16;
	localparam int VC_W      = 5;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int S_DATA_W  = 80;
	localparam int M_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DUR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_TICK     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_FROM_IN   = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_COUNT = 1'b1;

	typedef struct packed {
		logic              valid;
		logic              found_hi;
		logic [VIDX_W-1:0] idx_hi;
		logic              found_lo;
		logic [VIDX_W-1:0] idx_lo;
		logic [VCNT_W-1:0] busy;
	} scan_tok_t;

	typedef struct packed {
		logic [VIDX_W-1:0] start;
		logic [VCNT_W-1:0] n;
		logic              thr_neg;
	} scan_ctl_t;

	typedef struct packed {
		logic              en;
		logic [VIDX_W-1:0] idx;
	} exp_wr_t;

endpackage

// File: rtl/core/rrva_cell.sv
// One voice cell: holds a voice expiry and updates the scan token passing by.
// Depends on rrva_pkg.
module rrva_cell #(
	parameter int CELL_IDX  = 0,
	parameter int TIME_BITS = rrva_pkg::DEF_TIME_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrva_pkg::scan_ctl_t   ctl,
	input  logic [TIME_BITS-1:0]  now_t,
	input  logic [TIME_BITS-1:0]  thr_t,
	input  rrva_pkg::exp_wr_t     wr,
	input  logic [TIME_BITS-1:0]  wr_val,
	input  rrva_pkg::scan_tok_t   tok_i,
	output rrva_pkg::scan_tok_t   tok_o
);
	import rrva_pkg::*;

	localparam logic [VIDX_W-1:0] MY_IDX = VIDX_W'(CELL_IDX);
	localparam logic [VCNT_W-1:0] MY_POS = VCNT_W'(CELL_IDX);

	logic [TIME_BITS-1:0] expiry_q;
	scan_tok_t            tok_q;
	scan_tok_t            tok_nxt;
	logic                 active;
	logic                 is_free;
	logic                 is_busy;

	always_comb begin
		active  = tok_i.valid && (MY_POS < ctl.n);
		is_free = expiry_q <= now_t;
		is_busy = ctl.thr_neg || (expiry_q > thr_t);
		tok_nxt = tok_i;
		if (active && is_free && !tok_i.found_hi && (MY_IDX >= ctl.start)) begin
			tok_nxt.found_hi = 1'b1;
			tok_nxt.idx_hi   = MY_IDX;
		end
		if (active && is_free && !tok_i.found_lo) begin
			tok_nxt.found_lo = 1'b1;
			tok_nxt.idx_lo   = MY_IDX;
		end
		if (active && is_busy) begin
			tok_nxt.busy = tok_i.busy + VCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= '0;
		end else if (wr.en && (wr.idx == MY_IDX)) begin
			expiry_q <= wr_val;
		end
	end

	assign tok_o = tok_q;

endmodule

// File: rtl/core/round_robin_voice_allocator.sv
// Round-robin voice allocator: control, configuration and the chain of voice cells.
// Depends on rrva_pkg and rrva_cell.
// Items: a new input beat is taken only in the idle state, after setup, the token walking
// the cell chain and the result hand-off of the last item; the next beat also waits while
// a held result beat is not taken.
// Reset: all expiries, the start pointer and the remembered duration clear at once;
// voice_count resets to 16, other configuration registers to zero. No clearing pass.
module round_robin_voice_allocator #(
	parameter int MAX_VOICES = rrva_pkg::DEF_MAX_VOICES,
	parameter int TIME_BITS  = rrva_pkg::DEF_TIME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_time[47:0], note_duration[71:48], duration_present[72], zero pad
	input  logic [rrva_pkg::S_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// voice_index[3:0], granted[4], busy_count[9:5], zero pad
	output logic [rrva_pkg::M_DATA_W-1:0]  m_tdata,
	// is_count_reply
	output logic                           m_tuser,
	input  logic                           cfg_we,
	input  logic [rrva_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rrva_pkg::CFG_W-1:0]     cfg_wdata
);
	import rrva_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_WAIT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [7:0]           MAX8  = 8'(MAX_VOICES);
	localparam logic [63:0]          TMAX64 = 64'({TIME_BITS{1'b1}});

	logic [2:0]           state_q;
	logic [VC_W-1:0]      voice_count_q;
	logic [DUR_W-1:0]     default_dur_q;
	logic [HALF_W-1:0]    half_tick_q;
	logic                 dur_from_in_q;
	logic [DUR_W-1:0]     rem_dur_q;
	logic [VIDX_W-1:0]    ptr_q;

	logic                 op_q;
	logic [TIME_BITS-1:0] now_q;
	logic [DUR_W-1:0]     dur_q;
	logic [VCNT_W-1:0]    n_q;
	logic [VIDX_W-1:0]    start_q;
	logic [TIME_BITS-1:0] thr_q;
	logic                 thr_neg_q;
	logic [TIME_BITS:0]   sum_q;
	logic [TIME_BITS-1:0] exp_q;

	logic                 res_found_q;
	logic [VIDX_W-1:0]    res_idx_q;
	logic [VCNT_W-1:0]    res_cnt_q;

	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic                 m_tuser_q;

	logic                 accept;
	logic                 out_free;
	logic                 finish;
	logic [63:0]          now64;
	logic [TIME_BITS-1:0] now_clip;
	logic [7:0]           vc8;
	logic [7:0]           n8;
	logic [VCNT_W-1:0]    n_c;
	logic [HALF_W:0]      twice;
	logic [TIME_BITS:0]   diff;
	logic [VCNT_W-1:0]    v_next;
	logic [4:0]           busy_sat;

	scan_tok_t            tok [MAX_VOICES+1];
	scan_tok_t            tok_head;
	logic [MAX_VOICES:0]  tok_valid;
	scan_ctl_t            ctl;
	exp_wr_t              wr;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_DONE) && out_free;

	always_comb begin
		now64    = 64'(s_tdata[NOW_W-1:0]);
		now_clip = (now64 > TMAX64) ? {TIME_BITS{1'b1}} : now64[TIME_BITS-1:0];
		vc8      = 8'(voice_count_q);
		if (vc8 == 8'd0) begin
			n8 = 8'd1;
		end else if (vc8 > MAX8) begin
			n8 = MAX8;
		end else begin
			n8 = vc8;
		end
		n_c      = n8[VCNT_W-1:0];
		twice    = {half_tick_q, 1'b0};
		diff     = sum_q - (TIME_BITS+1)'(half_tick_q);
		v_next   = VCNT_W'(res_idx_q) + VCNT_W'(1);
		busy_sat = (res_cnt_q > VCNT_W'(31)) ? 5'd31 : res_cnt_q[4:0];
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_count_q <= VC_W'(16);
			default_dur_q <= '0;
			half_tick_q   <= '0;
			dur_from_in_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOICE_COUNT: voice_count_q <= cfg_wdata[VC_W-1:0];
				REG_DEFAULT_DUR: default_dur_q <= cfg_wdata[DUR_W-1:0];
				REG_HALF_TICK:   half_tick_q   <= cfg_wdata[HALF_W-1:0];
				REG_DUR_FROM_IN: dur_from_in_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rem_dur_q <= '0;
			ptr_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SETUP;
						if (s_tuser == OP_ALLOC && dur_from_in_q && s_tdata[NOW_W+DUR_W]) begin
							rem_dur_q <= s_tdata[NOW_W+DUR_W-1:NOW_W];
						end
					end
				end
				ST_SETUP:  state_q <= ST_LAUNCH;
				ST_LAUNCH: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (tok[MAX_VOICES].valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (op_q == OP_ALLOC && res_found_q) begin
							ptr_q <= (v_next >= n_q) ? '0 : v_next[VIDX_W-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			now_q   <= now_clip;
			n_q     <= n_c;
			start_q <= (VCNT_W'(ptr_q) < n_c) ? ptr_q : '0;
			if (!dur_from_in_q) begin
				dur_q <= default_dur_q;
			end else if (s_tdata[NOW_W+DUR_W]) begin
				dur_q <= s_tdata[NOW_W+DUR_W-1:NOW_W];
			end else begin
				dur_q <= rem_dur_q;
			end
		end
		if (state_q == ST_SETUP) begin
			thr_neg_q <= now_q < TIME_BITS'(twice);
			thr_q     <= now_q - TIME_BITS'(twice);
			sum_q     <= {1'b0, now_q} + (TIME_BITS+1)'(dur_q);
		end
		if (sum_q < (TIME_BITS+1)'(half_tick_q)) begin
			exp_q <= '0;
		end else if (diff[TIME_BITS]) begin
			exp_q <= {TIME_BITS{1'b1}};
		end else begin
			exp_q <= diff[TIME_BITS-1:0];
		end
		if (state_q == ST_WAIT && tok[MAX_VOICES].valid) begin
			res_found_q <= tok[MAX_VOICES].found_hi || tok[MAX_VOICES].found_lo;
			res_idx_q   <= tok[MAX_VOICES].found_hi ? tok[MAX_VOICES].idx_hi
			                                        : tok[MAX_VOICES].idx_lo;
			res_cnt_q   <= tok[MAX_VOICES].busy;
		end
	end

	// cell chain
	always_comb begin
		tok_head        = '0;
		tok_head.valid  = (state_q == ST_LAUNCH);
		ctl.start       = start_q;
		ctl.n           = n_q;
		ctl.thr_neg     = thr_neg_q;
		wr.en           = finish && (op_q == OP_ALLOC) && res_found_q;
		wr.idx          = res_idx_q;
		for (int i = 0; i <= MAX_VOICES; i++) begin
			tok_valid[i] = tok[i].valid;
		end
	end

	assign tok[0] = tok_head;

	for (genvar g = 0; g < MAX_VOICES; g++) begin : g_cell
		rrva_cell #(
			.CELL_IDX  (g),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.now_t  (now_q),
			.thr_t  (thr_q),
			.wr     (wr),
			.wr_val (exp_q),
			.tok_i  (tok[g]),
			.tok_o  (tok[g+1])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (op_q == OP_COUNT) begin
				m_tdata_q <= M_DATA_W'({busy_sat, 1'b0, 4'd0});
				m_tuser_q <= 1'b1;
			end else begin
				m_tdata_q <= M_DATA_W'({5'd0, res_found_q,
				                        res_found_q ? res_idx_q[3:0] : 4'd0});
				m_tuser_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one scan token in the cell chain");

	a_token_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_VOICES].valid |-> state_q == ST_WAIT)
		else $error("scan token left the chain outside the wait state");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SETUP)
		else $error("accepted beat did not start setup");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> VCNT_W'(ptr_q) < n_q)
		else $error("start pointer beyond voices in use after grant");
`endif

endmodule
